// ----- design/psod_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psod_pkg
// Shared types and constants of the position smoother, odometer and zone
// dwell timer.
// ----------------------------------------------------------------------------
package psod_pkg;

    // Item kinds.
    typedef logic [1:0] kind_t;
    localparam kind_t KIND_SAMPLE = 2'd0;
    localparam kind_t KIND_TICK   = 2'd1;
    localparam kind_t KIND_QUERY  = 2'd2;

    // Configuration register indexes.
    typedef logic [1:0] cfg_index_t;
    localparam cfg_index_t CFG_ALPHA  = 2'd0;
    localparam cfg_index_t CFG_WIDTH  = 2'd1;
    localparam cfg_index_t CFG_HEIGHT = 2'd2;

    localparam int CFG_DATA_W = 17;
    localparam int EXTENT_W   = 15;
    localparam int CELL_W     = 4;

    // Reset values of the configuration registers.
    localparam logic [16:0] ALPHA_RESET  = 17'd65536;
    localparam logic [14:0] EXTENT_RESET = 15'd2560;

    // Iterative divider: numerator and denominator widths.
    localparam int DIV_NUM_W = 28;
    localparam int DIV_DEN_W = 32;

    // Square root: operand bits and root bits.
    localparam int SQRT_OP_W   = 36;
    localparam int SQRT_ROOT_W = 18;

    localparam logic [9:0] SPEED_SCALE = 10'd1000;

endpackage

// ----- design/position_smoother_odometer_zone_dwell_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// position_smoother_odometer_zone_dwell_top
// Smooths position samples, keeps a saturating odometer and the latest
// speed, and accumulates dwell time per cell of a zone grid.
// ----------------------------------------------------------------------------
// The block takes one word at a time and returns one result word for each.
// A position sample passes through the smoothing multiply, the squaring, a
// bit-serial square root and the shared restoring divider for the speed.
// A dwell tick makes two passes of the divider to map the position to a
// column and a row, then a read-modify-write of the zone memory. A query
// reads the zone memory. The zone memory needs no clearing pass after
// reset: a valid flag per cell makes an unwritten cell read as zero. The
// next word is accepted while a finished result still waits in the output
// register.
// ----------------------------------------------------------------------------
module position_smoother_odometer_zone_dwell_top
#(
    parameter int ZONE_COLUMNS = 4,
    parameter int ZONE_LINES   = 4
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    // Configuration write port.
    input  logic                            cfg_we,
    input  psod_pkg::cfg_index_t            cfg_index,
    input  logic [psod_pkg::CFG_DATA_W-1:0] cfg_data,
    // Input channel.
    input  logic                            in_valid,
    output logic                            in_ready,
    input  psod_pkg::kind_t                 kind,
    input  logic signed [15:0]              x_in,
    input  logic signed [15:0]              y_in,
    input  logic [31:0]                     sample_time,
    input  logic [31:0]                     dwell_delta,
    input  logic [3:0]                      query_col,
    input  logic [3:0]                      query_row,
    // Output channel.
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [15:0]              smooth_x,
    output logic signed [15:0]              smooth_y,
    output logic [31:0]                     travelled,
    output logic [15:0]                     speed_now,
    output logic [31:0]                     dwell_value
);
    import psod_pkg::*;

    localparam int DEPTH = ZONE_COLUMNS * ZONE_LINES;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [CELL_W:0]    COLS_W   = (CELL_W + 1)'(ZONE_COLUMNS);
    localparam logic [CELL_W:0]    LINES_W  = (CELL_W + 1)'(ZONE_LINES);
    localparam logic [CELL_W-1:0]  COL_MAX  = CELL_W'(ZONE_COLUMNS - 1);
    localparam logic [CELL_W-1:0]  LINE_MAX = CELL_W'(ZONE_LINES - 1);

    // Sequencer states.
    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_EMA_X  = 5'd1;
    localparam logic [4:0] ST_EMA_Y  = 5'd2;
    localparam logic [4:0] ST_SQ_X   = 5'd3;
    localparam logic [4:0] ST_SQ_Y   = 5'd4;
    localparam logic [4:0] ST_SQRT   = 5'd5;
    localparam logic [4:0] ST_ODO    = 5'd6;
    localparam logic [4:0] ST_SPD_W  = 5'd7;
    localparam logic [4:0] ST_COMMIT = 5'd8;
    localparam logic [4:0] ST_ZC     = 5'd9;
    localparam logic [4:0] ST_ZC_W   = 5'd10;
    localparam logic [4:0] ST_ZR     = 5'd11;
    localparam logic [4:0] ST_ZR_W   = 5'd12;
    localparam logic [4:0] ST_ZRD    = 5'd13;
    localparam logic [4:0] ST_ZWR    = 5'd14;
    localparam logic [4:0] ST_QRD    = 5'd15;
    localparam logic [4:0] ST_QCAP   = 5'd16;
    localparam logic [4:0] ST_DONE   = 5'd17;

    logic [4:0]               state_reg;

    // Configuration.
    logic [16:0]              alpha_reg;
    logic [EXTENT_W-1:0]      width_reg;
    logic [EXTENT_W-1:0]      height_reg;

    // Captured input word.
    logic signed [15:0]       xin_reg;
    logic signed [15:0]       yin_reg;
    logic [31:0]              time_reg;
    logic [31:0]              delta_reg;

    // Tracking state.
    logic signed [15:0]       lastx_reg;
    logic signed [15:0]       lasty_reg;
    logic signed [15:0]       beforex_reg;
    logic signed [15:0]       beforey_reg;
    logic [31:0]              lasttime_reg;
    logic [31:0]              beforetime_reg;
    logic [1:0]               samples_reg;
    logic [31:0]              dist_reg;
    logic [15:0]              speed_reg;

    // Work registers.
    logic signed [15:0]       newx_reg;
    logic signed [15:0]       newy_reg;
    logic signed [34:0]       prod_reg;
    logic [32:0]              sq_reg;
    logic [SQRT_OP_W-1:0]     sq_op_reg;
    logic [20:0]              sq_rem_reg;
    logic [SQRT_ROOT_W-1:0]   sq_root_reg;
    logic [4:0]               sq_cnt_reg;
    logic [CELL_W-1:0]        col_reg;
    logic [IDX_W-1:0]         zaddr_reg;
    logic [31:0]              rd_reg;
    logic [DEPTH-1:0]         zvalid_reg;
    logic [31:0]              dwell_reg;

    // Output register.
    logic                     out_valid_reg;
    logic signed [15:0]       ox_reg;
    logic signed [15:0]       oy_reg;
    logic [31:0]              odist_reg;
    logic [15:0]              ospeed_reg;
    logic [31:0]              odwell_reg;

    // Zone memory.
    logic [31:0]              zmem [0:DEPTH-1];

    logic                     accept;
    logic                     out_free;

    // Smoothing multiplier: alpha times the step from the last position.
    logic signed [16:0]       ema_d;
    logic signed [17:0]       alpha_s;
    logic signed [34:0]       prod_w;
    logic signed [34:0]       round_w;
    logic signed [34:0]       ema_step;

    // Squaring multiplier for the step length.
    logic signed [16:0]       sq_d;
    logic signed [33:0]       sq_w;
    logic [33:0]              sq_sum;

    // Square root digit step.
    logic [22:0]              rt_rem_s;
    logic [22:0]              rt_trial;
    logic                     rt_fits;

    // Odometer, speed and divider hookup.
    logic [32:0]              odo_sum;
    logic [31:0]              dt_w;
    logic                     div_start;
    logic [DIV_NUM_W-1:0]     div_num;
    logic [DIV_DEN_W-1:0]     div_den;
    logic                     div_done;
    logic [DIV_NUM_W-1:0]     div_quo;
    logic [EXTENT_W-1:0]      ext_w;
    logic signed [15:0]       pos_w;
    logic [CELL_W-1:0]        cell_clamp;

    // Zone cell update.
    logic [7:0]               zidx_w;
    logic [7:0]               qidx_w;
    logic [31:0]              cell_w;
    logic [32:0]              cell_sum;
    logic                     query_in_grid;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || out_ready;

    assign alpha_s = {2'b00, alpha_reg[15:0]};
    assign ema_d   = (state_reg == ST_EMA_X)
                   ? ({xin_reg[15], xin_reg} - {lastx_reg[15], lastx_reg})
                   : ({yin_reg[15], yin_reg} - {lasty_reg[15], lasty_reg});
    assign prod_w   = alpha_s * ema_d;
    assign round_w  = prod_reg + 35'sd32768;
    assign ema_step = round_w >>> 16;

    assign sq_d   = (state_reg == ST_SQ_X)
                  ? ({newx_reg[15], newx_reg} - {lastx_reg[15], lastx_reg})
                  : ({newy_reg[15], newy_reg} - {lasty_reg[15], lasty_reg});
    assign sq_w   = sq_d * sq_d;
    assign sq_sum = {1'b0, sq_reg} + {1'b0, sq_w[32:0]};

    assign rt_rem_s = {sq_rem_reg, sq_op_reg[SQRT_OP_W-1 -: 2]};
    assign rt_trial = {3'b000, sq_root_reg, 2'b01};
    assign rt_fits  = (rt_rem_s >= rt_trial);

    assign odo_sum = {1'b0, dist_reg} + {15'd0, sq_root_reg};
    assign dt_w    = time_reg - lasttime_reg;

    // Divider operands: speed in ST_ODO, zone column and row otherwise.
    assign pos_w = (state_reg == ST_ZR) ? lasty_reg : lastx_reg;
    assign ext_w = (state_reg == ST_ZR) ? height_reg : width_reg;

    always_comb
    begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        case (state_reg)
            ST_ODO:
            begin
                div_start = 1'b1;
                div_num   = DIV_NUM_W'({10'd0, sq_root_reg} * {18'd0, SPEED_SCALE});
                div_den   = dt_w;
            end
            ST_ZC, ST_ZR:
            begin
                div_start = 1'b1;
                if (!pos_w[15])
                begin
                    div_num = DIV_NUM_W'({13'd0, pos_w[14:0]}
                                         * DIV_NUM_W'((state_reg == ST_ZR)
                                                      ? ZONE_LINES : ZONE_COLUMNS));
                end
                div_den = (ext_w == '0) ? DIV_DEN_W'(1) : DIV_DEN_W'(ext_w);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    // Clamp a divider quotient to the last column or row.
    always_comb
    begin
        if (state_reg == ST_ZR_W)
        begin
            cell_clamp = (div_quo >= DIV_NUM_W'(ZONE_LINES)) ? LINE_MAX
                                                             : div_quo[CELL_W-1:0];
        end
        else
        begin
            cell_clamp = (div_quo >= DIV_NUM_W'(ZONE_COLUMNS)) ? COL_MAX
                                                               : div_quo[CELL_W-1:0];
        end
    end

    assign zidx_w = {4'd0, cell_clamp} * 8'(ZONE_COLUMNS) + {4'd0, col_reg};
    assign qidx_w = {4'd0, query_row} * 8'(ZONE_COLUMNS) + {4'd0, query_col};
    assign query_in_grid = ({1'b0, query_col} < COLS_W) && ({1'b0, query_row} < LINES_W);

    // A cell never written reads as zero.
    assign cell_w   = zvalid_reg[zaddr_reg] ? rd_reg : 32'd0;
    assign cell_sum = {1'b0, cell_w} + {1'b0, delta_reg};

    psod_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    // Zone memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_ZWR)
        begin
            zmem[zaddr_reg] <= cell_sum[32] ? 32'hFFFF_FFFF : cell_sum[31:0];
        end
        if ((state_reg == ST_ZRD) || (state_reg == ST_QRD))
        begin
            rd_reg <= zmem[zaddr_reg];
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg  <= ALPHA_RESET;
            width_reg  <= EXTENT_RESET;
            height_reg <= EXTENT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ALPHA:  alpha_reg  <= cfg_data;
                CFG_WIDTH:  width_reg  <= cfg_data[EXTENT_W-1:0];
                CFG_HEIGHT: height_reg <= cfg_data[EXTENT_W-1:0];
                default:    alpha_reg  <= alpha_reg;
            endcase
        end
    end

    // Sequencer and tracking state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            lastx_reg      <= '0;
            lasty_reg      <= '0;
            beforex_reg    <= '0;
            beforey_reg    <= '0;
            lasttime_reg   <= '0;
            beforetime_reg <= '0;
            samples_reg    <= '0;
            dist_reg       <= '0;
            speed_reg      <= '0;
            zvalid_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            // The final state reloads the output register itself.
            if (out_valid_reg && out_ready && (state_reg != ST_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        case (kind)
                            KIND_SAMPLE:
                            begin
                                if (samples_reg == 2'd0)
                                begin
                                    state_reg <= ST_COMMIT;
                                end
                                else if (!alpha_reg[16])
                                begin
                                    state_reg <= ST_EMA_X;
                                end
                                else
                                begin
                                    state_reg <= ST_SQ_X;
                                end
                            end
                            KIND_TICK:
                            begin
                                state_reg <= (samples_reg == 2'd0) ? ST_DONE : ST_ZC;
                            end
                            KIND_QUERY:
                            begin
                                state_reg <= query_in_grid ? ST_QRD : ST_DONE;
                            end
                            default:
                            begin
                                state_reg <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_EMA_X:  state_reg <= ST_EMA_Y;
                ST_EMA_Y:  state_reg <= ST_SQ_X;
                ST_SQ_X:   state_reg <= ST_SQ_Y;
                ST_SQ_Y:   state_reg <= ST_SQRT;
                ST_SQRT:
                begin
                    if (sq_cnt_reg == 5'(SQRT_ROOT_W - 1))
                    begin
                        state_reg <= ST_ODO;
                    end
                end
                ST_ODO:
                begin
                    dist_reg  <= odo_sum[32] ? 32'hFFFF_FFFF : odo_sum[31:0];
                    state_reg <= ST_SPD_W;
                end
                ST_SPD_W:
                begin
                    if (div_done)
                    begin
                        if (dt_w == 32'd0)
                        begin
                            speed_reg <= '0;
                        end
                        else if (div_quo[DIV_NUM_W-1:16] != '0)
                        begin
                            speed_reg <= 16'hFFFF;
                        end
                        else
                        begin
                            speed_reg <= div_quo[15:0];
                        end
                        state_reg <= ST_COMMIT;
                    end
                end
                ST_COMMIT:
                begin
                    beforex_reg    <= lastx_reg;
                    beforey_reg    <= lasty_reg;
                    beforetime_reg <= lasttime_reg;
                    lastx_reg      <= newx_reg;
                    lasty_reg      <= newy_reg;
                    lasttime_reg   <= time_reg;
                    if (samples_reg != 2'd2)
                    begin
                        samples_reg <= samples_reg + 2'd1;
                    end
                    state_reg <= ST_DONE;
                end
                ST_ZC:     state_reg <= ST_ZC_W;
                ST_ZC_W:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_ZR;
                    end
                end
                ST_ZR:     state_reg <= ST_ZR_W;
                ST_ZR_W:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_ZRD;
                    end
                end
                ST_ZRD:    state_reg <= ST_ZWR;
                ST_ZWR:
                begin
                    zvalid_reg[zaddr_reg] <= 1'b1;
                    state_reg             <= ST_DONE;
                end
                ST_QRD:    state_reg <= ST_QCAP;
                ST_QCAP:   state_reg <= ST_DONE;
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:   state_reg <= ST_IDLE;
            endcase
        end
    end

    // Work datapath.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    xin_reg   <= x_in;
                    yin_reg   <= y_in;
                    newx_reg  <= x_in;
                    newy_reg  <= y_in;
                    time_reg  <= sample_time;
                    delta_reg <= dwell_delta;
                    dwell_reg <= '0;
                    zaddr_reg <= qidx_w[IDX_W-1:0];
                end
            end
            ST_EMA_X:
            begin
                prod_reg <= prod_w;
            end
            ST_EMA_Y:
            begin
                newx_reg <= lastx_reg + ema_step[15:0];
                prod_reg <= prod_w;
            end
            ST_SQ_X:
            begin
                if (!alpha_reg[16])
                begin
                    newy_reg <= lasty_reg + ema_step[15:0];
                end
                sq_reg <= sq_w[32:0];
            end
            ST_SQ_Y:
            begin
                sq_op_reg   <= {2'b00, sq_sum};
                sq_rem_reg  <= '0;
                sq_root_reg <= '0;
                sq_cnt_reg  <= '0;
            end
            ST_SQRT:
            begin
                sq_op_reg  <= {sq_op_reg[SQRT_OP_W-3:0], 2'b00};
                sq_cnt_reg <= sq_cnt_reg + 5'd1;
                if (rt_fits)
                begin
                    sq_rem_reg  <= 21'(rt_rem_s - rt_trial);
                    sq_root_reg <= {sq_root_reg[SQRT_ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    sq_rem_reg  <= rt_rem_s[20:0];
                    sq_root_reg <= {sq_root_reg[SQRT_ROOT_W-2:0], 1'b0};
                end
            end
            ST_ZC_W:
            begin
                if (div_done)
                begin
                    col_reg <= cell_clamp;
                end
            end
            ST_ZR_W:
            begin
                if (div_done)
                begin
                    zaddr_reg <= zidx_w[IDX_W-1:0];
                end
            end
            ST_QCAP:
            begin
                dwell_reg <= cell_w;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    ox_reg     <= lastx_reg;
                    oy_reg     <= lasty_reg;
                    odist_reg  <= dist_reg;
                    ospeed_reg <= speed_reg;
                    odwell_reg <= dwell_reg;
                end
            end
            default:
            begin
                col_reg <= col_reg;
            end
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign smooth_x    = ox_reg;
    assign smooth_y    = oy_reg;
    assign travelled   = odist_reg;
    assign speed_now   = ospeed_reg;
    assign dwell_value = odwell_reg;

    // The sample counter saturates at two.
    a_samples_sat : assert property (@(posedge clk) disable iff (!rst_n)
        samples_reg != 2'd3)
        else $error("sample counter passed two");

    // Speed stays zero until two samples are held; the first speed is set
    // one state before the second sample is committed.
    a_speed_zero : assert property (@(posedge clk) disable iff (!rst_n)
        ((samples_reg != 2'd2) && (state_reg != ST_COMMIT)) |-> (speed_reg == 16'd0))
        else $error("speed set before two samples");

    // The divider only finishes while the sequencer waits for it.
    a_div_owner : assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> ((state_reg == ST_SPD_W) || (state_reg == ST_ZC_W)
                      || (state_reg == ST_ZR_W)))
        else $error("divider finished with nobody waiting");

    // A result is only loaded from the final state.
    a_out_load : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result loaded outside the final state");

endmodule

// ----- design/psod_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psod_div
// Restoring divider: one quotient bit per cycle, shared by the speed
// calculation and the zone mapping.
// ----------------------------------------------------------------------------
module psod_div
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [psod_pkg::DIV_NUM_W-1:0] num,
    input  logic [psod_pkg::DIV_DEN_W-1:0] den,
    output logic                           done,
    output logic [psod_pkg::DIV_NUM_W-1:0] quo
);
    import psod_pkg::*;

    localparam int CNT_W = $clog2(DIV_NUM_W);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [DIV_NUM_W-1:0] shift_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_DEN_W:0]   rem_shift;
    logic                 fits;

    // Bring down the next numerator bit and try the subtraction.
    assign rem_shift = {rem_reg, shift_reg[DIV_NUM_W-1]};
    assign fits      = (rem_shift >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: the quotient bits shift in where the numerator shifts out.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg <= num;
            den_reg   <= den;
            rem_reg   <= '0;
        end
        else if (busy_reg)
        begin
            shift_reg <= {shift_reg[DIV_NUM_W-2:0], fits};
            if (fits)
            begin
                rem_reg <= DIV_DEN_W'(rem_shift - {1'b0, den_reg});
            end
            else
            begin
                rem_reg <= rem_shift[DIV_DEN_W-1:0];
            end
        end
    end

    assign done = done_reg;
    assign quo  = shift_reg;

endmodule

// ----- tb/psod_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psod_checker
// Watches both channels and the configuration port of the position smoother,
// keeps its own model of the smoothing, odometer, speed and zone dwell state,
// and compares every result word field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module psod_checker
#(
    parameter int ZONE_COLUMNS = 4,
    parameter int ZONE_LINES   = 4
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  psod_pkg::cfg_index_t            cfg_index,
    input  logic [psod_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  psod_pkg::kind_t                 kind,
    input  logic signed [15:0]              x_in,
    input  logic signed [15:0]              y_in,
    input  logic [31:0]                     sample_time,
    input  logic [31:0]                     dwell_delta,
    input  logic [3:0]                      query_col,
    input  logic [3:0]                      query_row,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic signed [15:0]              smooth_x,
    input  logic signed [15:0]              smooth_y,
    input  logic [31:0]                     travelled,
    input  logic [15:0]                     speed_now,
    input  logic [31:0]                     dwell_value,
    output int                              fail_count,
    output int                              pending
);
    import psod_pkg::*;

    typedef struct packed {
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic [31:0]        travel;
        logic [15:0]        speed;
        logic [31:0]        dwell;
    } position_report_t;

    position_report_t expected_reports[$];

    // Model state and configuration.
    logic [16:0]        alpha_q;
    logic [14:0]        width_q;
    logic [14:0]        height_q;
    logic signed [15:0] cur_x, cur_y, prev_x, prev_y;
    logic [31:0]        cur_t, prev_t;
    int                 fix_count;
    logic [31:0]        odometer;
    logic [31:0]        zone_ms [ZONE_LINES*ZONE_COLUMNS];

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root;
        root = 0;
        for (int b = 31; b >= 0; b--)
        begin
            longint unsigned trial;
            trial = root | (64'd1 << b);
            if (trial * trial <= v)
                root = trial;
        end
        return root;
    endfunction

    function automatic longint unsigned step_length(int ax, int ay, int bx, int by);
        longint dx, dy;
        dx = ax - bx;
        dy = ay - by;
        return int_sqrt(dx * dx + dy * dy);
    endfunction

    function automatic logic signed [15:0] blend(int fresh, int old, longint a);
        longint num;
        num = a * (fresh + 32768) + (65536 - a) * (old + 32768) + 32768;
        return 16'(int'(num >>> 16) - 32768);
    endfunction

    function automatic int cell_of(int v, int extent, int cells);
        longint idx;
        if (extent == 0)
            extent = 1;
        if (v < 0)
            return 0;
        idx = (longint'(v) * cells) / extent;
        return (idx >= cells) ? cells - 1 : int'(idx);
    endfunction

    function automatic logic [15:0] speed_estimate();
        logic [31:0]     dt;
        longint unsigned s;
        if (fix_count < 2)
            return 16'd0;
        dt = cur_t - prev_t;
        if (dt == 0)
            return 16'd0;
        s = step_length(cur_x, cur_y, prev_x, prev_y) * 1000 / dt;
        return (s > 65535) ? 16'hFFFF : 16'(s);
    endfunction

    // Apply one accepted word to the model and queue its result.
    task automatic predict_word();
        position_report_t r;
        int               nx, ny, k;
        longint unsigned  sum;
        r.dwell = '0;
        if (kind == KIND_SAMPLE)
        begin
            nx = x_in;
            ny = y_in;
            if (fix_count > 0 && alpha_q < 17'd65536)
            begin
                nx = blend(nx, cur_x, alpha_q);
                ny = blend(ny, cur_y, alpha_q);
            end
            if (fix_count > 0)
            begin
                sum = longint'(odometer) + step_length(nx, ny, cur_x, cur_y);
                odometer = (sum > 64'hFFFFFFFF) ? 32'hFFFFFFFF : 32'(sum);
            end
            prev_x = cur_x;
            prev_y = cur_y;
            prev_t = cur_t;
            cur_x  = 16'(nx);
            cur_y  = 16'(ny);
            cur_t  = sample_time;
            if (fix_count < 2)
                fix_count++;
        end
        else if (kind == KIND_TICK)
        begin
            if (fix_count > 0)
            begin
                k = cell_of(cur_y, height_q, ZONE_LINES) * ZONE_COLUMNS
                    + cell_of(cur_x, width_q, ZONE_COLUMNS);
                sum = longint'(zone_ms[k]) + longint'(dwell_delta);
                zone_ms[k] = (sum > 64'hFFFFFFFF) ? 32'hFFFFFFFF : 32'(sum);
            end
        end
        else if (kind == KIND_QUERY)
        begin
            if (query_col < ZONE_COLUMNS && query_row < ZONE_LINES)
                r.dwell = zone_ms[query_row * ZONE_COLUMNS + query_col];
        end
        r.sx     = cur_x;
        r.sy     = cur_y;
        r.travel = odometer;
        r.speed  = speed_estimate();
        expected_reports.push_back(r);
    endtask

    task automatic compare_word();
        position_report_t e;
        if (expected_reports.size() == 0)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("Unexpected result word at %0t", $realtime);
            return;
        end
        e = expected_reports.pop_front();
        if (e.sx !== smooth_x || e.sy !== smooth_y || e.travel !== travelled
            || e.speed !== speed_now || e.dwell !== dwell_value)
        begin
            fail_count++;
            if (fail_count <= 10)
            begin
                $display("Mismatch at %0t: exp x=%0d y=%0d d=%0d v=%0d w=%0d",
                         $realtime, e.sx, e.sy, e.travel, e.speed, e.dwell);
                $display("    got x=%0d y=%0d d=%0d v=%0d w=%0d",
                         smooth_x, smooth_y, travelled, speed_now, dwell_value);
            end
        end
    endtask

    // Sample every channel at the rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_q    = ALPHA_RESET;
            width_q    = EXTENT_RESET;
            height_q   = EXTENT_RESET;
            cur_x      = '0;
            cur_y      = '0;
            prev_x     = '0;
            prev_y     = '0;
            cur_t      = '0;
            prev_t     = '0;
            fix_count  = 0;
            odometer   = '0;
            fail_count = 0;
            foreach (zone_ms[i])
                zone_ms[i] = '0;
            expected_reports.delete();
            pending    = 0;
        end
        else
        begin
            if (out_valid && out_ready)
                compare_word();
            if (cfg_we)
            begin
                if (cfg_index == CFG_ALPHA)
                    alpha_q = cfg_data;
                else if (cfg_index == CFG_WIDTH)
                    width_q = cfg_data[14:0];
                else if (cfg_index == CFG_HEIGHT)
                    height_q = cfg_data[14:0];
            end
            if (in_valid && in_ready)
                predict_word();
            pending = expected_reports.size();
        end
    end

endmodule

// ----- tb/position_smoother_odometer_zone_dwell_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// position_smoother_odometer_zone_dwell_top_tb
// Drives samples, dwell ticks and zone queries into the block under several
// register settings, with random idling on both sides and one long output
// stall, while a checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module position_smoother_odometer_zone_dwell_top_tb;
    import psod_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    cfg_index_t            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    kind_t                 kind;
    logic signed [15:0]    x_in;
    logic signed [15:0]    y_in;
    logic [31:0]           sample_time;
    logic [31:0]           dwell_delta;
    logic [3:0]            query_col;
    logic [3:0]            query_row;
    logic                  out_valid;
    logic                  out_ready;
    logic signed [15:0]    smooth_x;
    logic signed [15:0]    smooth_y;
    logic [31:0]           travelled;
    logic [15:0]           speed_now;
    logic [31:0]           dwell_value;
    int                    fail_count;
    int                    pending;
    logic                  quiet_phase;
    logic                  hold_output;
    int                    idle_cycles;
    logic [31:0]           clock_ms;

    position_smoother_odometer_zone_dwell_top DUT (.*);
    psod_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver: random stall bursts, none in the quiet phase or while held.
    always
    begin
        @(posedge clk);
        if (hold_output || (!quiet_phase && $urandom_range(0, 3) == 0))
        begin
            out_ready <= 1'b0;
            if (!hold_output)
                repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        else
            out_ready <= 1'b1;
    end

    // Watchdog on cycles with no accepted input word and no taken result.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL position_smoother_odometer_zone_dwell_top");
            $finish;
        end
    end

    // One register write; the enable drops for a cycle before the next one.
    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one word and wait for its acceptance; may idle first. Valid stays
    // high after acceptance until the next word, an idle stretch or a drain replaces it.
    task automatic send_word(kind_t k, int x, int y, logic [31:0] t,
                             logic [31:0] d, int col, int row);
        if (!quiet_phase && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        kind        <= k;
        x_in        <= 16'(x);
        y_in        <= 16'(y);
        sample_time <= t;
        dwell_delta <= d;
        query_col   <= 4'(col);
        query_row   <= 4'(row);
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    // A random word, mostly samples walking through the room and ticks.
    task automatic random_word();
        int     sel;
        kind_t  k;
        sel = $urandom_range(0, 9);
        clock_ms = clock_ms + $urandom_range(0, 400);
        if (sel < 4)
        begin
            if ($urandom_range(0, 7) == 0)
                send_word(KIND_SAMPLE, $urandom, $urandom, $urandom, $urandom, 0, 0);
            else
                send_word(KIND_SAMPLE, $urandom_range(0, 2800) - 100,
                          $urandom_range(0, 2800) - 100, clock_ms, $urandom, 0, 0);
        end
        else if (sel < 7)
            send_word(KIND_TICK, $urandom, $urandom, $urandom,
                      ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 5000),
                      $urandom, $urandom);
        else if (sel < 9)
            send_word(KIND_QUERY, $urandom, $urandom, $urandom, $urandom,
                      $urandom_range(0, 15), $urandom_range(0, 15));
        else
        begin
            k = 2'd3;
            send_word(k, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = CFG_ALPHA;
        cfg_data    = '0;
        in_valid    = 1'b0;
        kind        = KIND_SAMPLE;
        x_in        = '0;
        y_in        = '0;
        sample_time = '0;
        dwell_delta = '0;
        query_col   = '0;
        query_row   = '0;
        out_ready   = 1'b0;
        quiet_phase = 1'b0;
        hold_output = 1'b0;
        idle_cycles = 0;
        clock_ms    = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: tick and query before any sample, first sample, extremes.
        send_word(KIND_TICK, 0, 0, 0, 100, 0, 0);
        send_word(KIND_QUERY, 0, 0, 0, 0, 0, 0);
        send_word(KIND_SAMPLE, 32767, 32767, 32'hFFFFFFFF, 0, 0, 0);
        send_word(KIND_SAMPLE, -32768, -32768, 32'hFFFFFFFF, 0, 0, 0);
        send_word(KIND_SAMPLE, 32767, -32768, 32'h00000000, 0, 0, 0);
        send_word(KIND_SAMPLE, 32767, -32768, 32'h00000001, 0, 0, 0);
        send_word(KIND_TICK, 0, 0, 0, 32'hFFFFFFF0, 0, 0);
        send_word(KIND_TICK, 0, 0, 0, 32'hFFFFFFFF, 0, 0);
        send_word(KIND_QUERY, 0, 0, 0, 0, 3, 0);
        send_word(KIND_QUERY, 0, 0, 0, 0, 15, 15);
        send_word(KIND_QUERY, 0, 0, 0, 0, 4, 0);
        send_word(KIND_QUERY, 0, 0, 0, 0, 0, 4);
        send_word(KIND_SAMPLE, 1000, 1500, 32'h10, 0, 0, 0);
        send_word(KIND_TICK, 0, 0, 0, 250, 0, 0);
        send_word(KIND_QUERY, 0, 0, 0, 0, 1, 2);
        send_word(2'd3, 16'hFFFF, 16'hFFFF, '1, '1, 15, 15);
        drain();

        // Settings: extremes and midpoints of every register.
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: begin write_reg(CFG_ALPHA, 17'd0);      write_reg(CFG_WIDTH, 15'd1);
                         write_reg(CFG_HEIGHT, 15'd32767); end
                1: begin write_reg(CFG_ALPHA, 17'd32768);  write_reg(CFG_WIDTH, 15'd2560);
                         write_reg(CFG_HEIGHT, 15'd2560); end
                2: begin write_reg(CFG_ALPHA, 17'd65535);  write_reg(CFG_WIDTH, 15'd32767);
                         write_reg(CFG_HEIGHT, 15'd1); end
                3: begin write_reg(CFG_ALPHA, 17'h1FFFF);  write_reg(CFG_WIDTH, 15'd0);
                         write_reg(CFG_HEIGHT, 15'd0); end
                4: begin write_reg(CFG_ALPHA, 17'($urandom_range(1, 65535)));
                         write_reg(CFG_WIDTH, 15'($urandom_range(1, 4000)));
                         write_reg(CFG_HEIGHT, 15'($urandom_range(1, 4000))); end
                default: begin write_reg(CFG_ALPHA, 17'd65536);
                         write_reg(CFG_WIDTH, 15'd2000); write_reg(CFG_HEIGHT, 15'd1600);
                         quiet_phase <= 1'b1; end
            endcase
            if (phase == 1)
            begin
                // Long output stall while words keep coming.
                fork
                    begin
                        hold_output <= 1'b1;
                        repeat (600) @(posedge clk);
                        hold_output <= 1'b0;
                    end
                    repeat (20) random_word();
                join
            end
            repeat (105) random_word();
            drain();
        end

        if (fail_count == 0)
            $display("PASS position_smoother_odometer_zone_dwell_top");
        else
            $display("FAIL position_smoother_odometer_zone_dwell_top");
        $finish;
    end

endmodule
